[rtl/core/ncl_pkg.sv]
package ncl_pkg;

    // Fixed field widths
    localparam int DIST_W  = 32;
    localparam int RANK_W  = 4;
    localparam int COUNT_W = 5;

    // Reset value of the candidate count register
    localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;

    // Command broadcast from the control logic to every cell
    typedef struct packed {
        logic ins;    // insert the accepted item
        logic drain;  // move every entry one place towards the head
        logic clr;    // empty the whole list
    } t_cell_cmd;

endpackage

[rtl/core/ncl_cell.sv]
module ncl_cell
    import ncl_pkg::*;
#(
    parameter int NODE_W = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_cmd         i_cmd,
    input  logic              i_active,
    input  logic [NODE_W-1:0] i_node,
    input  logic [DIST_W-1:0] i_dist,
    input  logic              i_prev_take,
    input  logic [NODE_W-1:0] i_prev_node,
    input  logic [DIST_W-1:0] i_prev_dist,
    input  logic              i_prev_filled,
    input  logic [NODE_W-1:0] i_next_node,
    input  logic [DIST_W-1:0] i_next_dist,
    input  logic              i_next_filled,
    output logic              o_take,
    output logic [NODE_W-1:0] o_node,
    output logic [DIST_W-1:0] o_dist,
    output logic              o_filled
);

    logic              r_filled;
    logic [NODE_W-1:0] r_node;
    logic [DIST_W-1:0] r_dist;

    // The new item belongs here or earlier when this slot is empty or farther
    assign o_take = i_active && (!r_filled || (i_dist < r_dist));

    // Control: filled flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filled <= 1'b0;
        end else if (i_cmd.clr) begin
            r_filled <= 1'b0;
        end else if (i_cmd.ins) begin
            if (i_prev_take && i_active) begin
                r_filled <= i_prev_filled;
            end else if (o_take) begin
                r_filled <= 1'b1;
            end
        end else if (i_cmd.drain) begin
            r_filled <= i_next_filled;
        end
    end

    // Payload: shift down on insertion, shift up on drain
    always_ff @(posedge i_clk) begin
        if (i_cmd.ins) begin
            if (i_prev_take && i_active) begin
                r_node <= i_prev_node;
                r_dist <= i_prev_dist;
            end else if (o_take) begin
                r_node <= i_node;
                r_dist <= i_dist;
            end
        end else if (i_cmd.drain) begin
            r_node <= i_next_node;
            r_dist <= i_next_dist;
        end
    end

    assign o_node   = r_node;
    assign o_dist   = r_dist;
    assign o_filled = r_filled;

endmodule

[rtl/core/nearest_candidate_list_builder_core.sv]
// Nearest candidate list builder.
// Input channel (i_in_valid / o_in_stall) carries one distance matrix entry
// per transfer: row, candidate node, distance and an end-of-row flag. The
// block keeps the k nearest candidates of the row in a chain of LIST_DEPTH
// cells, sorted nearest first; k is the candidate count register (0 acts as
// 1, values above LIST_DEPTH act as LIST_DEPTH).
// Throughput: one entry per cycle while a row streams in; each cell compares
// the new distance with its own entry and takes its neighbour's data.
// On the end-of-row transfer the list is emitted on the output channel
// (o_out_valid / i_out_stall) as k results, rank 0 first, the last one
// flagged; empty slots read as node 0, distance 0. The first result appears
// after the end-of-row transfer, once the chain head is registered, then one
// per cycle, draining the chain towards its head. The input is stalled while
// results drain, then the list is cleared and the next row may start.
// A stalled result holds in the output register and halts the drain.
// Reset (synchronous, active low) empties the list, drops any pending
// result and sets the candidate count to 16.
module nearest_candidate_list_builder_core
    import ncl_pkg::*;
#(
    parameter int LIST_DEPTH = 16,
    parameter int NODE_LIMIT = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [COUNT_W-1:0]            i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [$clog2(NODE_LIMIT)-1:0] i_row_index,
    input  logic [$clog2(NODE_LIMIT)-1:0] i_node_index,
    input  logic [DIST_W-1:0]             i_distance,
    input  logic                          i_last_in_row,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [RANK_W-1:0]             o_rank,
    output logic [$clog2(NODE_LIMIT)-1:0] o_cand_node,
    output logic [DIST_W-1:0]             o_cand_distance,
    output logic                          o_last_of_run
);

    localparam int NODE_W = $clog2(NODE_LIMIT);
    localparam int K_W    = $clog2(LIST_DEPTH + 1);

    logic [COUNT_W-1:0] r_count;
    logic [K_W-1:0]     k_eff;

    logic               r_busy;
    logic [K_W-1:0]     r_cnt;

    logic               r_out_valid;
    logic [RANK_W-1:0]  r_out_rank;
    logic [NODE_W-1:0]  r_out_node;
    logic [DIST_W-1:0]  r_out_dist;
    logic               r_out_last;

    logic               in_xfer;
    logic               load;
    logic               load_last;
    t_cell_cmd          cmd;

    logic [LIST_DEPTH-1:0] take;
    logic [LIST_DEPTH-1:0] filled;
    logic [NODE_W-1:0]     node [LIST_DEPTH];
    logic [DIST_W-1:0]     chain_dist [LIST_DEPTH];

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= COUNT_RESET;
        end else if (i_cfg_we) begin
            r_count <= i_cfg_data;
        end
    end

    // Clamp the count into 1..LIST_DEPTH
    always_comb begin
        if (r_count == '0) begin
            k_eff = K_W'(1);
        end else if (32'(r_count) > 32'(LIST_DEPTH)) begin
            k_eff = K_W'(LIST_DEPTH);
        end else begin
            k_eff = K_W'(r_count);
        end
    end

    // Handshake and chain commands
    assign in_xfer   = i_in_valid && !r_busy;
    assign load      = r_busy && (!r_out_valid || !i_out_stall);
    assign load_last = (r_cnt == k_eff - K_W'(1));

    always_comb begin
        cmd.ins   = in_xfer && (i_node_index != i_row_index);
        cmd.drain = load && !load_last;
        cmd.clr   = load && load_last;
    end

    // Chain of cells
    for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
        logic              prev_take;
        logic [NODE_W-1:0] prev_node;
        logic [DIST_W-1:0] prev_dist;
        logic              prev_filled;
        logic [NODE_W-1:0] next_node;
        logic [DIST_W-1:0] next_dist;
        logic              next_filled;

        if (g == 0) begin : g_head
            assign prev_take   = 1'b0;
            assign prev_node   = '0;
            assign prev_dist   = '0;
            assign prev_filled = 1'b0;
        end else begin : g_body
            assign prev_take   = take[g-1];
            assign prev_node   = node[g-1];
            assign prev_dist   = chain_dist[g-1];
            assign prev_filled = filled[g-1];
        end

        if (g == LIST_DEPTH - 1) begin : g_tail
            assign next_node   = '0;
            assign next_dist   = '0;
            assign next_filled = 1'b0;
        end else begin : g_inner
            assign next_node   = node[g+1];
            assign next_dist   = chain_dist[g+1];
            assign next_filled = filled[g+1];
        end

        ncl_cell #(
            .NODE_W(NODE_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (cmd),
            .i_active     (K_W'(g) < k_eff),
            .i_node       (i_node_index),
            .i_dist       (i_distance),
            .i_prev_take  (prev_take),
            .i_prev_node  (prev_node),
            .i_prev_dist  (prev_dist),
            .i_prev_filled(prev_filled),
            .i_next_node  (next_node),
            .i_next_dist  (next_dist),
            .i_next_filled(next_filled),
            .o_take       (take[g]),
            .o_node       (node[g]),
            .o_dist       (chain_dist[g]),
            .o_filled     (filled[g])
        );
    end

    // Emission control: hold off input while the list drains
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer && i_last_in_row) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (load) begin
                if (load_last) begin
                    r_busy <= 1'b0;
                    r_cnt  <= '0;
                end else begin
                    r_cnt <= r_cnt + K_W'(1);
                end
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output register: take the head of the chain, empty slots read as zero
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_rank <= RANK_W'(r_cnt);
            r_out_node <= filled[0] ? node[0] : '0;
            r_out_dist <= filled[0] ? chain_dist[0] : '0;
            r_out_last <= load_last;
        end
    end

    assign o_in_stall      = r_busy;
    assign o_out_valid     = r_out_valid;
    assign o_rank          = r_out_rank;
    assign o_cand_node     = r_out_node;
    assign o_cand_distance = r_out_dist;
    assign o_last_of_run   = r_out_last;

endmodule

[rtl/core/ncl_checker.sv]
module ncl_checker
    import ncl_pkg::*;
#(
    parameter int NODE_W = 10
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [RANK_W-1:0] o_rank,
    input logic [NODE_W-1:0] o_cand_node,
    input logic [DIST_W-1:0] o_cand_distance,
    input logic              o_last_of_run
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_rank)
            && $stable(o_cand_node) && $stable(o_cand_distance)
            && $stable(o_last_of_run))
        else $error("stalled result changed");

    // Ranks of one row follow without gaps
    a_rank_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_last_of_run |=>
            o_out_valid && (o_rank == RANK_W'($past(o_rank) + 1'b1)))
        else $error("rank sequence broken");

    // Input held off until the row's last result is presented
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last_of_run |-> o_in_stall)
        else $error("input accepted during emission");

endmodule

bind nearest_candidate_list_builder_core ncl_checker #(
    .NODE_W($clog2(NODE_LIMIT))
) u_ncl_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_rank         (o_rank),
    .o_cand_node    (o_cand_node),
    .o_cand_distance(o_cand_distance),
    .o_last_of_run  (o_last_of_run)
);

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import ncl_pkg::*;

    localparam int LIST_DEPTH    = 16;
    localparam int NODE_LIMIT    = 1024;
    localparam int NODE_W        = $clog2(NODE_LIMIT);
    localparam int RANDOM_ITEMS  = 350;
    localparam int SETTLE_CYCLES = 4;
    localparam int LONG_HOLD     = 60;
    localparam int IDLE_LIMIT    = 2000;

    typedef struct packed {
        logic [NODE_W-1:0] row;
        logic [NODE_W-1:0] node;
        logic [DIST_W-1:0] distance;
        logic              last;
    } t_matrix_entry;

    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic [NODE_W-1:0] node;
        logic [DIST_W-1:0] distance;
        logic              last;
    } t_rank_entry;

    // DUT inputs, known from time zero
    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_cfg_we      = 1'b0;
    logic [COUNT_W-1:0] i_cfg_data    = '0;
    logic               i_in_valid    = 1'b0;
    logic [NODE_W-1:0]  i_row_index   = '0;
    logic [NODE_W-1:0]  i_node_index  = '0;
    logic [DIST_W-1:0]  i_distance    = '0;
    logic               i_last_in_row = 1'b0;
    logic               i_out_stall   = 1'b0;

    logic               o_in_stall;
    logic               o_out_valid;
    logic [RANK_W-1:0]  o_rank;
    logic [NODE_W-1:0]  o_cand_node;
    logic [DIST_W-1:0]  o_cand_distance;
    logic               o_last_of_run;

    // Predicted list and register copy
    logic [NODE_W-1:0]  slot_node [LIST_DEPTH];
    logic [DIST_W-1:0]  slot_dist [LIST_DEPTH];
    logic               slot_used [LIST_DEPTH];
    logic [COUNT_W-1:0] count_shadow = COUNT_RESET;

    t_matrix_entry      pending_entries [$];
    t_rank_entry        expected_ranks [$];

    int unsigned        error_count    = 0;
    int unsigned        entries_sent   = 0;
    int unsigned        ranks_checked  = 0;
    int unsigned        rows_closed    = 0;
    int unsigned        count_writes   = 0;
    int unsigned        idle_cycles    = 0;

    nearest_candidate_list_builder_core #(
        .LIST_DEPTH (LIST_DEPTH),
        .NODE_LIMIT (NODE_LIMIT)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_row_index     (i_row_index),
        .i_node_index    (i_node_index),
        .i_distance      (i_distance),
        .i_last_in_row   (i_last_in_row),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_rank          (o_rank),
        .o_cand_node     (o_cand_node),
        .o_cand_distance (o_cand_distance),
        .o_last_of_run   (o_last_of_run)
    );

    // Clock: 20 ns period
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Effective list length: zero acts as one, clamp to the list depth
    function automatic int kept_limit();
        if (count_shadow == 0)
            return 1;
        if (count_shadow > LIST_DEPTH)
            return LIST_DEPTH;
        return int'(count_shadow);
    endfunction

    function automatic void clear_slots();
        for (int t = 0; t < LIST_DEPTH; t++) begin
            slot_node[t] = '0;
            slot_dist[t] = '0;
            slot_used[t] = 1'b0;
        end
    endfunction

    // Insert one matrix entry into the predicted list; close the row on its last entry
    function automatic void update_nearest_list(input t_matrix_entry e);
        int          k;
        int          at;
        t_rank_entry r;
        k = kept_limit();
        if (e.node != e.row) begin
            at = k;
            // first empty slot, or first entry strictly farther
            for (int t = k - 1; t >= 0; t--)
                if (!slot_used[t] || e.distance < slot_dist[t])
                    at = t;
            if (at < k) begin
                for (int t = k - 1; t > at; t--) begin
                    slot_node[t] = slot_node[t-1];
                    slot_dist[t] = slot_dist[t-1];
                    slot_used[t] = slot_used[t-1];
                end
                slot_node[at] = e.node;
                slot_dist[at] = e.distance;
                slot_used[at] = 1'b1;
            end
        end
        if (e.last) begin
            for (int t = 0; t < k; t++) begin
                r.rank     = RANK_W'(t);
                r.node     = slot_used[t] ? slot_node[t] : '0;
                r.distance = slot_used[t] ? slot_dist[t] : '0;
                r.last     = (t == k - 1);
                expected_ranks.push_back(r);
            end
            clear_slots();
            rows_closed++;
        end
    endfunction

    // Mostly back to back, some short gaps, a few long ones
    function automatic int unsigned random_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    // Input driver: hold the payload while stalled, advance on each transfer
    int unsigned send_gap    = 0;
    int unsigned send_steady = 0;
    t_matrix_entry cur_entry;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall)
                update_nearest_list(cur_entry);
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_entries.size() != 0) begin
                    cur_entry = pending_entries.pop_front();
                    i_row_index   <= cur_entry.row;
                    i_node_index  <= cur_entry.node;
                    i_distance    <= cur_entry.distance;
                    i_last_in_row <= cur_entry.last;
                    i_in_valid    <= 1'b1;
                    entries_sent++;
                    if (send_steady > 0) begin
                        send_steady--;
                    end else begin
                        send_gap = random_gap();
                        if ($urandom_range(0, 19) == 0)
                            send_steady = $urandom_range(15, 50);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: check each transfer against the oldest prediction
    int unsigned stall_left    = 0;
    int unsigned recv_steady   = 0;
    bit          pressure_done = 1'b0;
    t_rank_entry want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_ranks.size() == 0) begin
                    $display("%0t: unexpected result rank %0d node %0d distance %0h",
                             $time, o_rank, o_cand_node, o_cand_distance);
                    error_count++;
                end else begin
                    want = expected_ranks.pop_front();
                    ranks_checked++;
                    if (o_rank !== want.rank) begin
                        $display("%0t: rank expected %0d actual %0d",
                                 $time, want.rank, o_rank);
                        error_count++;
                    end
                    if (o_cand_node !== want.node) begin
                        $display("%0t: cand_node expected %0d actual %0d (rank %0d)",
                                 $time, want.node, o_cand_node, want.rank);
                        error_count++;
                    end
                    if (o_cand_distance !== want.distance) begin
                        $display("%0t: cand_distance expected %0h actual %0h (rank %0d)",
                                 $time, want.distance, o_cand_distance, want.rank);
                        error_count++;
                    end
                    if (o_last_of_run !== want.last) begin
                        $display("%0t: last_of_run expected %0b actual %0b (rank %0d)",
                                 $time, want.last, o_last_of_run, want.rank);
                        error_count++;
                    end
                end
            end
            // one long hold-off mid-run, while the sender waits, to back the block up
            if (!pressure_done && o_out_valid && i_in_valid && ranks_checked >= 150) begin
                pressure_done = 1'b1;
                stall_left = LONG_HOLD;
                i_out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (recv_steady > 0) begin
                recv_steady--;
                i_out_stall <= 1'b0;
            end else begin
                stall_left = random_gap();
                if (stall_left > 0) begin
                    stall_left--;
                    i_out_stall <= 1'b1;
                end else begin
                    i_out_stall <= 1'b0;
                    if ($urandom_range(0, 19) == 0)
                        recv_steady = $urandom_range(15, 50);
                end
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Wait for every queued entry and every predicted result, then let the block settle
    task automatic wait_drained();
        while (pending_entries.size() != 0 || i_in_valid || expected_ranks.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_count(input logic [COUNT_W-1:0] value);
        i_cfg_data <= value;
        i_cfg_we   <= 1'b1;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        count_shadow = value;
        count_writes++;
    endtask

    task automatic queue_entry(input int row, input int node,
                               input logic [DIST_W-1:0] distance, input bit last);
        t_matrix_entry e;
        e.row      = NODE_W'(row);
        e.node     = NODE_W'(node);
        e.distance = distance;
        e.last     = last;
        pending_entries.push_back(e);
    endtask

    function automatic logic [COUNT_W-1:0] pick_count();
        case ($urandom_range(0, 9))
            0: return 5'd0;
            1: return 5'd1;
            2: return 5'd16;
            3: return 5'd31;
            4: return 5'd17;
            default: return COUNT_W'($urandom_range(0, 31));
        endcase
    endfunction

    function automatic logic [DIST_W-1:0] pick_distance(input int unsigned style);
        case (style)
            0: return $urandom;
            1: return DIST_W'($urandom_range(0, 15));
            default: begin
                case ($urandom_range(0, 2))
                    0: return '0;
                    1: return '1;
                    default: return $urandom;
                endcase
            end
        endcase
    endfunction

    // Stimulus and end of run
    initial begin
        int unsigned counted;
        int unsigned rows_here;
        int unsigned row_len;
        int unsigned style;
        int          row;
        int          node;
        bit          open_end;
        bit          last;

        clear_slots();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset count: skipped row node, node zero, ties, extremes, empty ranks
        queue_entry(5, 1023, 32'hFFFF_FFFF, 1'b0);
        queue_entry(5, 5, 32'd1, 1'b0);
        queue_entry(5, 0, 32'd7, 1'b0);
        queue_entry(5, 1, 32'd0, 1'b0);
        queue_entry(5, 2, 32'd7, 1'b0);
        queue_entry(5, 3, 32'd100, 1'b1);
        wait_drained();

        // single slot: ties do not displace, skip on row zero
        write_count(5'd1);
        queue_entry(0, 0, 32'd3, 1'b0);
        queue_entry(0, 9, 32'd50, 1'b0);
        queue_entry(0, 4, 32'd10, 1'b0);
        queue_entry(0, 8, 32'd10, 1'b0);
        queue_entry(0, 1023, 32'hFFFF_FFFF, 1'b1);
        wait_drained();

        // zero count acts as one; lone skipped entry emits an empty rank
        write_count(5'd0);
        queue_entry(1023, 1023, 32'd0, 1'b1);
        wait_drained();

        // three slots, nearer entries push the far ones off the end
        write_count(5'd3);
        queue_entry(7, 11, 32'd50, 1'b0);
        queue_entry(7, 12, 32'd40, 1'b0);
        queue_entry(7, 13, 32'd30, 1'b0);
        queue_entry(7, 14, 32'd20, 1'b0);
        queue_entry(7, 15, 32'd10, 1'b1);
        wait_drained();

        // count shrinks mid-row; stale slots must be gone in the next row
        write_count(5'd4);
        queue_entry(9, 21, 32'd5, 1'b0);
        queue_entry(9, 22, 32'd3, 1'b0);
        queue_entry(9, 23, 32'd9, 1'b0);
        wait_drained();
        write_count(5'd2);
        queue_entry(9, 24, 32'd1, 1'b1);
        wait_drained();
        write_count(5'd31);
        queue_entry(10, 1, 32'd2, 1'b1);

        // random phases of whole rows, some left open across a count change
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            wait_drained();
            write_count(pick_count());
            rows_here = $urandom_range(1, 4);
            for (int r = 0; r < rows_here; r++) begin
                case ($urandom_range(0, 9))
                    0: row = 0;
                    1: row = NODE_LIMIT - 1;
                    default: row = $urandom_range(0, NODE_LIMIT - 1);
                endcase
                row_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(1, 16);
                style = $urandom_range(0, 2);
                open_end = (r == rows_here - 1) && ($urandom_range(0, 5) == 0);
                for (int i = 0; i < row_len; i++) begin
                    node = ($urandom_range(0, 9) == 0) ? row
                                                       : $urandom_range(0, NODE_LIMIT - 1);
                    last = (i == row_len - 1) && !open_end;
                    queue_entry(row, node, pick_distance(style), last);
                    if (node != row || last)
                        counted++;
                end
            end
        end
        wait_drained();
        repeat (2 * LIST_DEPTH) @(posedge i_clk);

        if (expected_ranks.size() != 0) begin
            $display("%0t: %0d predicted results never arrived", $time, expected_ranks.size());
            error_count++;
        end
        $display("Run covered %0d input transfers over %0d rows and %0d count writes,",
                 entries_sent, rows_closed, count_writes);
        $display("with %0d ranks checked and %0d mismatches.", ranks_checked, error_count);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
